/* sv/dr2m_pkg.sv */
// Types, register codes and note helpers shared by the drum-report-to-MIDI block.
`default_nettype none
package dr2m_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIDI_CHANNEL     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEDAL_VEL        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTE_TABLE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HAT_PEDAL_SELECT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HAT_PAD_SELECT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_HAT_NOTE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSED_HAT_NOTE  = 3'd6;
    localparam int unsigned CFG_DATA_W = 63;

    // Register reset values
    localparam logic [3:0] RST_MIDI_CHANNEL     = 4'd9;
    localparam logic [6:0] RST_PEDAL_VEL        = 7'd100;
    localparam logic [6:0] RST_OPEN_HAT_NOTE    = 7'd46;
    localparam logic [6:0] RST_CLOSED_HAT_NOTE  = 7'd42;

    // Hat override modes
    localparam logic [1:0] MODE_TABLE  = 2'd0;
    localparam logic [1:0] MODE_CLOSED = 2'd1;
    localparam logic [1:0] MODE_OPEN   = 2'd2;

    // Hat pedal select codes
    localparam logic [1:0] HAT_PEDAL_ORANGE = 2'd1;
    localparam logic [1:0] HAT_PEDAL_BLACK  = 2'd2;

    // Note table entries
    localparam int unsigned NOTE_W      = 7;
    localparam logic [3:0]  NOTE_CYM_OFS = 4'd3;
    localparam logic [3:0]  NOTE_ORANGE  = 4'd7;
    localparam logic [3:0]  NOTE_BLACK   = 4'd8;

    // Event slots: pad i uses 2i (off) and 2i+1 (on), then the two pedals
    localparam int unsigned NUM_PADS   = 4;
    localparam int unsigned NUM_EVT    = 10;
    localparam int unsigned EVT_ORANGE = 8;
    localparam int unsigned EVT_BLACK  = 9;

    // Velocity clamp constants
    localparam logic [8:0] VEL_BASE = 9'd280;
    localparam logic [6:0] VEL_MAX  = 7'd127;

    typedef struct packed {
        logic [7:0] red_level;
        logic [7:0] yellow_level;
        logic [7:0] blue_level;
        logic [7:0] green_level;
        logic       cym_sel;
        logic       orange_pedal;
        logic       black_pedal;
    } t_in_item;

    typedef struct packed {
        logic [6:0] note_number;
        logic [6:0] note_velocity;
        logic       is_note_on;
        logic [3:0] channel_out;
        logic       last_event;
    } t_out_item;

    typedef struct packed {
        logic [3:0]  midi_channel;
        logic [6:0]  pedal_vel;
        logic [62:0] note_table;
        logic [1:0]  hat_pedal_select;
        logic [3:0]  hat_pad_select;
        logic [6:0]  open_hat_note;
        logic [6:0]  closed_hat_note;
    } t_cfg;

    typedef struct packed {
        logic [6:0] note;
        logic [6:0] vel;
        logic       on;
    } t_event;

    typedef t_event [NUM_EVT-1:0] t_evt_bank;

    typedef struct packed {
        logic bank_free;
    } t_ser_status;

    // Note of a table entry, with the hat override applied
    function automatic logic [6:0] note_of(input t_cfg cfg, input logic [3:0] idx,
                                           input logic [1:0] mode);
        logic [6:0] n;
        n = cfg.note_table[NOTE_W*int'(idx) +: NOTE_W];
        if ((idx + 4'd1) == cfg.hat_pad_select) begin
            if (mode == MODE_CLOSED) begin
                n = cfg.closed_hat_note;
            end else if (mode == MODE_OPEN) begin
                n = cfg.open_hat_note;
            end
        end
        return n;
    endfunction

    // min((280 - level) * 2, 127) for a nonzero level
    function automatic logic [6:0] pad_velocity(input logic [7:0] level);
        logic [8:0] diff;
        diff = VEL_BASE - {1'b0, level};
        return (diff[8:6] != 3'd0) ? VEL_MAX : {diff[5:0], 1'b0};
    endfunction

endpackage
`default_nettype wire

/* sv/dr2m_cfg_regs.sv */
// Configuration register file of the drum-report-to-MIDI block.
`default_nettype none
module dr2m_cfg_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_valid,
    input  wire logic [dr2m_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [dr2m_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output dr2m_pkg::t_cfg                       o_cfg
);
    import dr2m_pkg::*;

    t_cfg r_cfg;

    // Decode the index and update one register per transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.midi_channel     <= RST_MIDI_CHANNEL;
            r_cfg.pedal_vel        <= RST_PEDAL_VEL;
            r_cfg.note_table       <= '0;
            r_cfg.hat_pedal_select <= '0;
            r_cfg.hat_pad_select   <= '0;
            r_cfg.open_hat_note    <= RST_OPEN_HAT_NOTE;
            r_cfg.closed_hat_note  <= RST_CLOSED_HAT_NOTE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MIDI_CHANNEL:     r_cfg.midi_channel     <= i_cfg_data[3:0];
                CFG_PEDAL_VEL:        r_cfg.pedal_vel        <= i_cfg_data[6:0];
                CFG_NOTE_TABLE:       r_cfg.note_table       <= i_cfg_data[62:0];
                CFG_HAT_PEDAL_SELECT: r_cfg.hat_pedal_select <= i_cfg_data[1:0];
                CFG_HAT_PAD_SELECT:   r_cfg.hat_pad_select   <= i_cfg_data[3:0];
                CFG_OPEN_HAT_NOTE:    r_cfg.open_hat_note    <= i_cfg_data[6:0];
                CFG_CLOSED_HAT_NOTE:  r_cfg.closed_hat_note  <= i_cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

/* sv/dr2m_event_build.sv */
// Edge detection, hat override tracking and event list construction for one report.
`default_nettype none
module dr2m_event_build (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire dr2m_pkg::t_in_item        i_item,
    input  wire logic                      i_load,
    input  wire dr2m_pkg::t_cfg            i_cfg,
    output dr2m_pkg::t_evt_bank            o_bank,
    output logic [dr2m_pkg::NUM_EVT-1:0]   o_mask
);
    import dr2m_pkg::*;

    logic [NUM_PADS-1:0] r_prev_pad;
    logic [NUM_PADS-1:0] n_prev_pad;
    logic [1:0]          r_prev_pedal;
    logic [1:0]          n_prev_pedal;
    logic [1:0]          r_mode;
    logic [1:0]          n_mode;

    logic [7:0]          levels [NUM_PADS];
    logic [1:0]          pedals;
    logic [1:0]          mode_mid;
    logic [6:0]          pad_note;
    logic [6:0]          pad_vel;
    logic [3:0]          pad_idx;
    logic [6:0]          orange_note;
    logic [6:0]          black_note;

    assign levels[0] = i_item.red_level;
    assign levels[1] = i_item.yellow_level;
    assign levels[2] = i_item.blue_level;
    assign levels[3] = i_item.green_level;
    assign pedals    = {i_item.black_pedal, i_item.orange_pedal};

    // Build the pad events: note-off then note-on on a rising hit
    always_comb begin
        o_bank     = '0;
        o_mask     = '0;
        n_prev_pad = '0;
        pad_note   = '0;
        pad_vel    = '0;
        pad_idx    = '0;
        for (int i = 0; i < NUM_PADS; i++) begin
            pad_idx = (i_item.cym_sel && i != 0) ? (4'(i) + NOTE_CYM_OFS) : 4'(i);
            pad_note = note_of(i_cfg, pad_idx, r_mode);
            pad_vel  = pad_velocity(levels[i]);
            n_prev_pad[i] = (levels[i] != 8'd0);
            o_bank[2*i]   = '{note: pad_note, vel: 7'd0, on: 1'b0};
            o_bank[2*i+1] = '{note: pad_note, vel: pad_vel, on: 1'b1};
            o_mask[2*i]   = n_prev_pad[i] && !r_prev_pad[i];
            o_mask[2*i+1] = n_prev_pad[i] && !r_prev_pad[i];
        end

        // Orange pedal sees the mode in force before it, then may change it
        orange_note = note_of(i_cfg, NOTE_ORANGE, r_mode);
        o_bank[EVT_ORANGE] = '{note: orange_note,
                               vel: pedals[0] ? i_cfg.pedal_vel : 7'd0,
                               on: pedals[0]};
        o_mask[EVT_ORANGE] = pedals[0] != r_prev_pedal[0];
        mode_mid = r_mode;
        if (o_mask[EVT_ORANGE] && i_cfg.hat_pedal_select == HAT_PEDAL_ORANGE) begin
            mode_mid = pedals[0] ? MODE_CLOSED : MODE_OPEN;
        end

        // Black pedal sees the mode left by the orange pedal
        black_note = note_of(i_cfg, NOTE_BLACK, mode_mid);
        o_bank[EVT_BLACK] = '{note: black_note,
                              vel: pedals[1] ? i_cfg.pedal_vel : 7'd0,
                              on: pedals[1]};
        o_mask[EVT_BLACK] = pedals[1] != r_prev_pedal[1];
        n_mode = mode_mid;
        if (o_mask[EVT_BLACK] && i_cfg.hat_pedal_select == HAT_PEDAL_BLACK) begin
            n_mode = pedals[1] ? MODE_CLOSED : MODE_OPEN;
        end
        n_prev_pedal = pedals;
    end

    // Advance the history when the report moves into the event bank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_pad   <= '0;
            r_prev_pedal <= '0;
            r_mode       <= MODE_TABLE;
        end else if (i_load) begin
            r_prev_pad   <= n_prev_pad;
            r_prev_pedal <= n_prev_pedal;
            r_mode       <= n_mode;
        end
    end

endmodule
`default_nettype wire

/* sv/dr2m_event_serial.sv */
// Event bank and output register: one pending event per unstalled cycle, in slot order.
`default_nettype none
module dr2m_event_serial (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_load,
    input  wire dr2m_pkg::t_evt_bank       i_bank,
    input  wire logic [dr2m_pkg::NUM_EVT-1:0] i_mask,
    input  wire logic [3:0]                i_channel,
    input  wire logic                      i_out_ready,
    output logic                           o_out_valid,
    output dr2m_pkg::t_out_item            o_out,
    output dr2m_pkg::t_ser_status          o_status
);
    import dr2m_pkg::*;

    t_evt_bank             r_bank;
    logic [NUM_EVT-1:0]    r_mask;
    logic [NUM_EVT-1:0]    n_mask;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic [NUM_EVT-1:0]    low_bit;
    logic [NUM_EVT-1:0]    rest;
    t_event                sel_evt;
    logic                  out_adv;

    // Pick the lowest pending slot
    always_comb begin
        low_bit = r_mask & (~r_mask + NUM_EVT'(1));
        rest    = r_mask & ~low_bit;
        sel_evt = '0;
        for (int i = 0; i < NUM_EVT; i++) begin
            if (low_bit[i]) begin
                sel_evt = r_bank[i];
            end
        end
    end

    assign out_adv = (r_mask != '0) && (!r_out_valid || i_out_ready);
    assign o_status.bank_free = (r_mask == '0) || (out_adv && rest == '0);

    // Load a new report or drop the slot just sent
    always_comb begin
        n_mask = r_mask;
        if (i_load) begin
            n_mask = i_mask;
        end else if (out_adv) begin
            n_mask = rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else begin
            r_mask <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bank <= i_bank;
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv) begin
            r_out.note_number   <= sel_evt.note;
            r_out.note_velocity <= sel_evt.vel;
            r_out.is_note_on    <= sel_evt.on;
            r_out.channel_out   <= i_channel;
            r_out.last_event    <= (rest == '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
`default_nettype wire

/* sv/drum_report_to_midi_events_core.sv */
// Top level: turns drum-kit reports into a stream of MIDI note events.
//
// Input channel (i_in_valid/o_in_ready/i_in) takes one report per transaction.
// Output channel (o_out_valid/i_out_ready/o_out) gives one note event per
// transaction; last_event marks the final event of a report, and a report
// with no pad or pedal edge gives no event at all.
// Configuration channel (i_cfg_valid/o_cfg_ready/i_cfg_index/i_cfg_data) is
// always ready and writes one register per transaction; write it only while
// no report is in flight.
// The first event of a report passes the input register, then the event
// bank, then the output register. A report holds the event bank until its
// last event moves to the output register, and gives up to ten events; the
// single output port, one event per cycle while the receiver is ready, sets
// the report rate. A report is held in the input register while the bank
// drains, so a new report is taken while events are still going out.
// Reset clears the pad, pedal and hat history, empties the pipeline and loads
// the register defaults. When the receiver stalls, the output register holds
// its event, the bank and then the input register fill, and o_in_ready falls.
`default_nettype none
module drum_report_to_midi_events_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire dr2m_pkg::t_in_item              i_in,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output dr2m_pkg::t_out_item                  o_out,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [dr2m_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [dr2m_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import dr2m_pkg::*;

    t_cfg               cfg;
    t_in_item           r_in;
    logic               r_in_valid;
    logic               in_accept;
    logic               load;
    t_evt_bank          bank;
    logic [NUM_EVT-1:0] mask;
    t_ser_status        ser_status;

    assign o_cfg_ready = 1'b1;

    dr2m_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Input register: move to the bank once the bank is free
    assign load       = r_in_valid && ser_status.bank_free;
    assign o_in_ready = !r_in_valid || load;
    assign in_accept  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in;
        end
    end

    dr2m_event_build u_build (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (r_in),
        .i_load  (load),
        .i_cfg   (cfg),
        .o_bank  (bank),
        .o_mask  (mask)
    );

    dr2m_event_serial u_serial (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_bank      (bank),
        .i_mask      (mask),
        .i_channel   (cfg.midi_channel),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .o_status    (ser_status)
    );

endmodule
`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for the drum-report-to-MIDI-event block.
module tb_top;
    import dr2m_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 24;
    localparam int RX_HOLD_CYCLES  = 200;
    localparam int SEGMENT_REPORTS = 68;
    localparam int NUM_SEGMENTS    = 6;
    localparam int MAX_SHOWN       = 10;

    // Register setup styles between random segments
    localparam int SETUP_RANDOM = 0;
    localparam int SETUP_MAX    = 1;
    localparam int SETUP_MIN    = 2;

    // Directed stimulus row: a report or a register write
    typedef struct {
        bit                    is_reg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        t_in_item              report;
        int                    n_typed;
        t_out_item [1:0]       typed;
    } t_drum_row;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in_item              in_item   = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_ready;
    logic                  out_valid;
    logic                  cfg_ready;
    t_out_item             out_event;

    // Predictor state and register shadow
    t_cfg       shadow_cfg;
    logic [3:0] pads_held    = '0;
    logic [1:0] pedals_held  = '0;
    logic [1:0] hat_override = MODE_TABLE;

    t_out_item fresh_events[$];
    t_out_item awaited_events[$];
    t_drum_row directed_rows[$];

    int src_idle_pct   = 0;
    int rx_idle_pct    = 0;
    int hold_seq       = 0;
    int err_count      = 0;
    int shown          = 0;
    int reports_sent   = 0;
    int events_checked = 0;
    int reg_writes     = 0;
    int idle_cycles    = 0;

    drum_report_to_midi_events_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_event),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic t_in_item rep(input logic [7:0] r, y, b, g, input logic cym, org, blk);
        rep = '{r, y, b, g, cym, org, blk};
    endfunction

    function automatic t_out_item ev(input logic [6:0] note, vel, input logic on,
                                     input logic [3:0] ch, input logic last);
        ev = '{note, vel, on, ch, last};
    endfunction

    function automatic t_out_item make_event(input logic [6:0] note, vel, input logic on);
        make_event = '{note, vel, on, shadow_cfg.midi_channel, 1'b0};
    endfunction

    // Mirror a register write, masked to the register width
    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_MIDI_CHANNEL:     shadow_cfg.midi_channel     = data[3:0];
            CFG_PEDAL_VEL:        shadow_cfg.pedal_vel        = data[6:0];
            CFG_NOTE_TABLE:       shadow_cfg.note_table       = data[62:0];
            CFG_HAT_PEDAL_SELECT: shadow_cfg.hat_pedal_select = data[1:0];
            CFG_HAT_PAD_SELECT:   shadow_cfg.hat_pad_select   = data[3:0];
            CFG_OPEN_HAT_NOTE:    shadow_cfg.open_hat_note    = data[6:0];
            CFG_CLOSED_HAT_NOTE:  shadow_cfg.closed_hat_note  = data[6:0];
            default: ;
        endcase
    endfunction

    // Table note of an entry, replaced by the hat note while an override is active
    function automatic logic [6:0] entry_note(input int idx);
        logic [6:0] n;
        int         sel;
        n   = shadow_cfg.note_table[NOTE_W*idx +: NOTE_W];
        sel = int'(shadow_cfg.hat_pad_select);
        if (sel >= 1 && sel <= 9 && idx == sel - 1) begin
            if (hat_override == MODE_CLOSED) begin
                n = shadow_cfg.closed_hat_note;
            end else if (hat_override == MODE_OPEN) begin
                n = shadow_cfg.open_hat_note;
            end
        end
        return n;
    endfunction

    // Work out the note events of one report and advance the kit history
    function automatic void predict_events(input t_in_item r);
        logic [7:0] levels [4];
        logic [1:0] pedals;
        logic [1:0] sel_code;
        logic [3:0] pads;
        logic [6:0] note;
        int         vel;
        int         idx;
        int         i;
        levels[0] = r.red_level;
        levels[1] = r.yellow_level;
        levels[2] = r.blue_level;
        levels[3] = r.green_level;
        pedals = {r.black_pedal, r.orange_pedal};
        pads = '0;
        fresh_events.delete();
        for (i = 0; i < NUM_PADS; i++) begin
            if (levels[i] != 8'd0) begin
                pads[i] = 1'b1;
                if (!pads_held[i]) begin
                    idx = (r.cym_sel && i != 0) ? i + int'(NOTE_CYM_OFS) : i;
                    note = entry_note(idx);
                    vel = (int'(VEL_BASE) - int'(levels[i])) * 2;
                    if (vel > int'(VEL_MAX)) begin
                        vel = int'(VEL_MAX);
                    end
                    fresh_events.push_back(make_event(note, 7'd0, 1'b0));
                    fresh_events.push_back(make_event(note, vel[6:0], 1'b1));
                end
            end
        end
        for (i = 0; i < 2; i++) begin
            if (pedals[i] != pedals_held[i]) begin
                note = entry_note(int'(NOTE_ORANGE) + i);
                sel_code = (i == 0) ? HAT_PEDAL_ORANGE : HAT_PEDAL_BLACK;
                if (pedals[i]) begin
                    fresh_events.push_back(make_event(note, shadow_cfg.pedal_vel, 1'b1));
                    if (shadow_cfg.hat_pedal_select == sel_code) begin
                        hat_override = MODE_CLOSED;
                    end
                end else begin
                    fresh_events.push_back(make_event(note, 7'd0, 1'b0));
                    if (shadow_cfg.hat_pedal_select == sel_code) begin
                        hat_override = MODE_OPEN;
                    end
                end
            end
        end
        pads_held = pads;
        pedals_held = pedals;
        if (fresh_events.size() > 0) begin
            fresh_events[fresh_events.size()-1].last_event = 1'b1;
        end
    endfunction

    function automatic logic [7:0] random_level();
        case ($urandom_range(9))
            0, 1, 2, 3: return 8'd0;
            4:          return 8'hFF;
            5:          return 8'd1;
            default:    return 8'($urandom_range(255, 1));
        endcase
    endfunction

    function automatic t_in_item random_report();
        return rep(random_level(), random_level(), random_level(), random_level(),
                   1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] setup_word(input int kind);
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        case (kind)
            SETUP_MAX: return '1;
            SETUP_MIN: return '0;
            default:   return w[CFG_DATA_W-1:0];
        endcase
    endfunction

    task automatic log_mismatch(input string why, input t_out_item want, input t_out_item got);
        err_count++;
        if (shown < MAX_SHOWN) begin
            shown++;
            $display("MISMATCH (%s): expected note=%0d vel=%0d on=%0d ch=%0d last=%0d",
                     why, want.note_number, want.note_velocity, want.is_note_on,
                     want.channel_out, want.last_event);
            $display("    got note=%0d vel=%0d on=%0d ch=%0d last=%0d",
                     got.note_number, got.note_velocity, got.is_note_on,
                     got.channel_out, got.last_event);
        end
    endtask

    // Offer one report, hold it until the transaction, then record its events
    task automatic send_report(input t_in_item r, input bit use_model);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item <= r;
        do @(posedge clk); while (!in_ready);
        reports_sent++;
        predict_events(r);
        if (use_model) begin
            foreach (fresh_events[k]) awaited_events.push_back(fresh_events[k]);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        apply_reg(idx, data);
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Stop offering reports, wait for every pending event, then let the pipeline settle
    task automatic drain_events();
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited_events.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_setup(input int kind);
        logic [CFG_DATA_W-1:0] pad_word;
        pad_word = setup_word(kind);
        if (kind == SETUP_RANDOM) begin
            pad_word[3:0] = 4'($urandom_range(9));
        end
        write_reg(CFG_MIDI_CHANNEL, setup_word(kind));
        write_reg(CFG_PEDAL_VEL, setup_word(kind));
        write_reg(CFG_NOTE_TABLE, setup_word(kind));
        write_reg(CFG_HAT_PEDAL_SELECT, setup_word(kind));
        write_reg(CFG_HAT_PAD_SELECT, pad_word);
        write_reg(CFG_OPEN_HAT_NOTE, setup_word(kind));
        write_reg(CFG_CLOSED_HAT_NOTE, setup_word(kind));
    endtask

    task automatic add_report(input t_in_item r, input int n, input t_out_item e0, e1);
        t_drum_row row;
        row.is_reg   = 1'b0;
        row.reg_idx  = '0;
        row.reg_data = '0;
        row.report   = r;
        row.n_typed  = n;
        row.typed    = {e1, e0};
        directed_rows.push_back(row);
    endtask

    task automatic add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        t_drum_row row;
        row.is_reg   = 1'b1;
        row.reg_idx  = idx;
        row.reg_data = data;
        row.report   = '0;
        row.n_typed  = 0;
        row.typed    = '0;
        directed_rows.push_back(row);
    endtask

    // Check each event transaction against the oldest pending event
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            events_checked++;
            if (awaited_events.size() == 0) begin
                log_mismatch("no event pending", '0, out_event);
            end else begin
                want = awaited_events.pop_front();
                if (out_event.note_number !== want.note_number ||
                    out_event.note_velocity !== want.note_velocity ||
                    out_event.is_note_on !== want.is_note_on ||
                    out_event.channel_out !== want.channel_out ||
                    out_event.last_event !== want.last_event) begin
                    log_mismatch("event", want, out_event);
                end
            end
        end
    end

    // Receiver: random back-pressure, plus one long hold on request
    initial begin
        int seen_hold;
        seen_hold = 0;
        forever begin
            @(negedge clk);
            if (hold_seq != seen_hold) begin
                seen_hold = hold_seq;
                out_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES - 1) @(negedge clk);
            end else begin
                out_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        t_drum_row row;
        bit        prev_reg;
        int        seg;
        int        n;

        // Register defaults after reset
        shadow_cfg                  = '0;
        shadow_cfg.midi_channel     = RST_MIDI_CHANNEL;
        shadow_cfg.pedal_vel        = RST_PEDAL_VEL;
        shadow_cfg.open_hat_note    = RST_OPEN_HAT_NOTE;
        shadow_cfg.closed_hat_note  = RST_CLOSED_HAT_NOTE;

        // Reset defaults: level extremes and a pedal, results typed in
        add_report(rep(0, 0, 0, 0, 0, 0, 0), 0, '0, '0);
        add_report(rep(255, 0, 0, 0, 0, 0, 0), 2, ev(0, 0, 0, RST_MIDI_CHANNEL, 0),
                   ev(0, 50, 1, RST_MIDI_CHANNEL, 1));
        add_report(rep(255, 0, 0, 0, 0, 0, 0), 0, '0, '0);
        add_report(rep(0, 0, 0, 0, 0, 0, 0), 0, '0, '0);
        add_report(rep(1, 0, 0, 0, 0, 0, 0), 2, ev(0, 0, 0, RST_MIDI_CHANNEL, 0),
                   ev(0, 127, 1, RST_MIDI_CHANNEL, 1));
        add_report(rep(1, 0, 0, 0, 0, 1, 0), 1,
                   ev(0, RST_PEDAL_VEL, 1, RST_MIDI_CHANNEL, 1), '0);
        add_report(rep(0, 0, 0, 0, 0, 0, 0), 1, ev(0, 0, 0, RST_MIDI_CHANNEL, 1), '0);
        // Distinct notes, orange pedal drives the yellow pad
        add_reg(CFG_NOTE_TABLE, {7'd44, 7'd35, 7'd57, 7'd51, 7'd49, 7'd45, 7'd48,
                                 7'd38, 7'd36});
        add_reg(CFG_MIDI_CHANNEL, 63'd0);
        add_reg(CFG_PEDAL_VEL, 63'd127);
        add_reg(CFG_HAT_PEDAL_SELECT, 63'(HAT_PEDAL_ORANGE));
        add_reg(CFG_HAT_PAD_SELECT, 63'd2);
        add_report(rep(255, 255, 255, 255, 0, 0, 0), -1, '0, '0);
        add_report(rep(0, 0, 0, 0, 0, 0, 0), -1, '0, '0);
        add_report(rep(128, 128, 128, 128, 1, 0, 0), -1, '0, '0);
        add_report(rep(0, 0, 0, 0, 0, 1, 0), -1, '0, '0);
        add_report(rep(0, 216, 0, 217, 0, 1, 0), -1, '0, '0);
        add_report(rep(0, 0, 0, 0, 0, 0, 0), -1, '0, '0);
        add_report(rep(0, 1, 0, 0, 0, 0, 0), -1, '0, '0);
        // The orange pedal follows itself as the hat entry
        add_reg(CFG_HAT_PAD_SELECT, 63'(NOTE_ORANGE + 4'd1));
        add_reg(CFG_MIDI_CHANNEL, 63'd15);
        add_reg(CFG_PEDAL_VEL, 63'd0);
        add_report(rep(0, 0, 0, 0, 0, 1, 1), -1, '0, '0);
        add_report(rep(0, 0, 0, 0, 0, 0, 0), -1, '0, '0);
        // Out-of-range selects, hat note extremes, a write past the register list
        add_reg(CFG_HAT_PEDAL_SELECT, 63'd3);
        add_reg(CFG_HAT_PAD_SELECT, 63'd12);
        add_reg(CFG_OPEN_HAT_NOTE, 63'd127);
        add_reg(CFG_CLOSED_HAT_NOTE, 63'd0);
        add_reg(CFG_CLOSED_HAT_NOTE + 3'd1, '1);
        add_report(rep(255, 1, 128, 64, 1, 1, 1), -1, '0, '0);
        add_report(rep(0, 0, 0, 0, 0, 0, 0), -1, '0, '0);
        // Black pedal drives the black entry
        add_reg(CFG_HAT_PAD_SELECT, 63'(NOTE_BLACK + 4'd1));
        add_reg(CFG_HAT_PEDAL_SELECT, 63'(HAT_PEDAL_BLACK));
        add_report(rep(0, 0, 0, 0, 0, 0, 1), -1, '0, '0);
        add_report(rep(0, 0, 0, 0, 0, 0, 0), -1, '0, '0);
        add_report(rep(7, 7, 7, 7, 1, 0, 1), -1, '0, '0);

        // Hold reset, then release it at a falling edge
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk the directed table; settle before each batch of writes
        src_idle_pct = 19;
        rx_idle_pct  = 57;
        prev_reg = 1'b0;
        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            if (row.is_reg) begin
                if (!prev_reg) begin
                    drain_events();
                end
                write_reg(row.reg_idx, row.reg_data);
            end else begin
                send_report(row.report, row.n_typed < 0);
                for (n = 0; n < row.n_typed; n++) begin
                    awaited_events.push_back(row.typed[n]);
                end
            end
            prev_reg = row.is_reg;
        end

        // Random segments: sender-light, then receiver-light, then no idling
        for (seg = 0; seg < NUM_SEGMENTS; seg++) begin
            drain_events();
            case (seg)
                1:       load_setup(SETUP_MAX);
                4:       load_setup(SETUP_MIN);
                default: load_setup(SETUP_RANDOM);
            endcase
            if (seg < 2) begin
                src_idle_pct = 19;
                rx_idle_pct  = 57;
            end else if (seg < 4) begin
                src_idle_pct = 57;
                rx_idle_pct  = 19;
            end else begin
                src_idle_pct = 0;
                rx_idle_pct  = 0;
            end
            if (seg == NUM_SEGMENTS - 1) begin
                hold_seq++;
            end
            for (n = 0; n < SEGMENT_REPORTS; n++) begin
                send_report(random_report(), 1'b1);
            end
        end

        drain_events();
        err_count += awaited_events.size();
        $display("Sent %0d drum reports, checked %0d note events, %0d register writes",
                 reports_sent, events_checked, reg_writes);
        $display("Covered hat overrides, cymbal notes, velocity clamp and back-pressure");
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
